// File: hw/rtl/round_robin_flow_queue_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// Round-robin flow queue scheduler: assertion macros
// Shared concurrent-assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_FLOW_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_FLOW_QUEUE_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge
`define RRFQS_ASSERT(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
// Consequent holds in the same cycle as the antecedent
`define RRFQS_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Consequent holds in the cycle after the antecedent
`define RRFQS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RRFQS_ASSERT(label, expr)
`define RRFQS_IMPLIES(label, ante, cons)
`define RRFQS_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/rrfqs_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin flow queue scheduler package
// Word types, status codes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrfqs_pkg;

  // Request kinds
  typedef enum logic [0:0] {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_EMPTY      = 2'd1,
    STATUS_TABLE_FULL = 2'd2,
    STATUS_QUEUE_FULL = 2'd3
  } status_e;

  // Input word
  typedef struct packed {
    req_e        req_type;
    logic [15:0] flow_id;
    logic [15:0] packet_id;
  } req_t;

  // Output word
  typedef struct packed {
    status_e     status;
    logic [15:0] out_packet_id;
    logic [15:0] out_flow_id;
  } rsp_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_LK_CHK,
    ST_DQ_CHK,
    ST_DQ_PKT,
    ST_RESP
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load_req;
    logic    lk_start;
    logic    lk_next;
    logic    alloc_wr;
    logic    enq_wr;
    logic    dq_start;
    logic    dq_next;
    logic    dq_take;
    logic    res_set;
    logic    res_pkt;
    status_e res_status;
    logic    out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic req_deq;
    logic no_flows;
    logic table_full;
    logic key_match;
    logic idx_last;
    logic queue_full;
    logic queue_nonempty;
    logic steps_last;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/rrfqs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrfqs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/rrfqs_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences flow lookup, allocation, enqueue, round-robin scan and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrfqs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rrfqs_pkg::sts_t   sts_i,
  output rrfqs_pkg::cmd_t   cmd_o
);

  rrfqs_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrfqs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      rrfqs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = rrfqs_pkg::ST_START;
        end
      end
      rrfqs_pkg::ST_START: begin
        if (sts_i.req_deq) begin
          if (sts_i.no_flows) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = rrfqs_pkg::STATUS_EMPTY;
            state_d          = rrfqs_pkg::ST_RESP;
          end else begin
            cmd_o.dq_start = 1'b1;
            state_d        = rrfqs_pkg::ST_DQ_CHK;
          end
        end else if (sts_i.no_flows) begin
          // first flow ever: allocate slot zero straight away
          cmd_o.alloc_wr   = 1'b1;
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = rrfqs_pkg::STATUS_OK;
          state_d          = rrfqs_pkg::ST_RESP;
        end else begin
          cmd_o.lk_start = 1'b1;
          state_d        = rrfqs_pkg::ST_LK_CHK;
        end
      end
      rrfqs_pkg::ST_LK_CHK: begin
        if (sts_i.key_match) begin
          cmd_o.res_set = 1'b1;
          if (sts_i.queue_full) begin
            cmd_o.res_status = rrfqs_pkg::STATUS_QUEUE_FULL;
          end else begin
            cmd_o.enq_wr     = 1'b1;
            cmd_o.res_status = rrfqs_pkg::STATUS_OK;
          end
          state_d = rrfqs_pkg::ST_RESP;
        end else if (sts_i.idx_last) begin
          cmd_o.res_set = 1'b1;
          if (sts_i.table_full) begin
            cmd_o.res_status = rrfqs_pkg::STATUS_TABLE_FULL;
          end else begin
            cmd_o.alloc_wr   = 1'b1;
            cmd_o.res_status = rrfqs_pkg::STATUS_OK;
          end
          state_d = rrfqs_pkg::ST_RESP;
        end else begin
          cmd_o.lk_next = 1'b1;
        end
      end
      rrfqs_pkg::ST_DQ_CHK: begin
        if (sts_i.queue_nonempty) begin
          cmd_o.dq_take = 1'b1;
          state_d       = rrfqs_pkg::ST_DQ_PKT;
        end else if (sts_i.steps_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = rrfqs_pkg::STATUS_EMPTY;
          state_d          = rrfqs_pkg::ST_RESP;
        end else begin
          cmd_o.dq_next = 1'b1;
        end
      end
      rrfqs_pkg::ST_DQ_PKT: begin
        cmd_o.res_set    = 1'b1;
        cmd_o.res_pkt    = 1'b1;
        cmd_o.res_status = rrfqs_pkg::STATUS_OK;
        state_d          = rrfqs_pkg::ST_RESP;
      end
      rrfqs_pkg::ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = rrfqs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rrfqs_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != rrfqs_pkg::ST_IDLE);

endmodule

// File: hw/rtl/rrfqs_dp.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Flow-state memory, packet memory, slot counters and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "round_robin_flow_queue_scheduler_top_defines.svh"

module rrfqs_dp #(
  parameter int MAX_FLOWS   = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrfqs_pkg::req_t   in_word_i,
  input  rrfqs_pkg::cmd_t   cmd_i,
  output rrfqs_pkg::sts_t   sts_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output rrfqs_pkg::rsp_t   out_word_o
);

  localparam int SLOT_W    = $clog2(MAX_FLOWS);
  localparam int NUM_W     = $clog2(MAX_FLOWS + 1);
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int PKT_DEPTH = MAX_FLOWS * QUEUE_DEPTH;
  localparam int PADDR_W   = $clog2(PKT_DEPTH);
  localparam int ENT_W     = 16 + 2 * PTR_W + CNT_W;

  // Per-flow state held in one memory word
  typedef struct packed {
    logic [15:0]      key;
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [CNT_W-1:0] count;
  } entry_t;

  rrfqs_pkg::req_t     req_q;
  rrfqs_pkg::rsp_t     res_q;
  rrfqs_pkg::rsp_t     out_word_q;
  logic                out_valid_q;
  logic [SLOT_W-1:0]   idx_q;
  logic [SLOT_W-1:0]   steps_q;
  logic [SLOT_W-1:0]   ptr_q;
  logic [NUM_W-1:0]    nflows_q;
  logic [15:0]         key_q;

  logic                fr_re, fr_we;
  logic [SLOT_W-1:0]   fr_raddr, fr_waddr;
  logic [ENT_W-1:0]    fr_rdata;
  entry_t              fr_rd_ent, fr_wr_ent;

  logic                pr_re, pr_we;
  logic [PADDR_W-1:0]  pk_addr;
  logic [15:0]         pr_rdata;
  logic [SLOT_W-1:0]   pk_slot;
  logic [PTR_W-1:0]    pk_pos;

  logic [SLOT_W-1:0]   idx_inc, idx_wrap, new_slot;
  logic                idx_last, steps_last;
  logic [PTR_W-1:0]    head_nx, tail_nx;

  assign fr_rd_ent = entry_t'(fr_rdata);
  assign new_slot  = nflows_q[SLOT_W-1:0];

  // Slot index stepping, wrapping at the number of flows in use
  assign idx_inc    = idx_q + SLOT_W'(1);
  assign idx_last   = (NUM_W'(idx_q) + NUM_W'(1)) == nflows_q;
  assign idx_wrap   = idx_last ? '0 : idx_inc;
  assign steps_last = (NUM_W'(steps_q) + NUM_W'(1)) == nflows_q;

  // Circular queue pointer advance
  assign head_nx = (fr_rd_ent.head == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                              : fr_rd_ent.head + PTR_W'(1);
  assign tail_nx = (fr_rd_ent.tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                              : fr_rd_ent.tail + PTR_W'(1);

  // Flow-state memory access
  always_comb begin
    fr_re = cmd_i.lk_start | cmd_i.lk_next | cmd_i.dq_start | cmd_i.dq_next;
    if (cmd_i.lk_start) begin
      fr_raddr = '0;
    end else if (cmd_i.lk_next) begin
      fr_raddr = idx_inc;
    end else if (cmd_i.dq_start) begin
      fr_raddr = ptr_q;
    end else begin
      fr_raddr = idx_wrap;
    end

    fr_we     = cmd_i.alloc_wr | cmd_i.enq_wr | cmd_i.dq_take;
    fr_waddr  = cmd_i.alloc_wr ? new_slot : idx_q;
    fr_wr_ent = fr_rd_ent;
    if (cmd_i.alloc_wr) begin
      fr_wr_ent.key   = req_q.flow_id;
      fr_wr_ent.head  = '0;
      fr_wr_ent.tail  = PTR_W'(1);
      fr_wr_ent.count = CNT_W'(1);
    end else if (cmd_i.enq_wr) begin
      fr_wr_ent.tail  = tail_nx;
      fr_wr_ent.count = fr_rd_ent.count + CNT_W'(1);
    end else begin
      fr_wr_ent.head  = head_nx;
      fr_wr_ent.count = fr_rd_ent.count - CNT_W'(1);
    end
  end

  // Packet memory address: slot base plus queue position
  always_comb begin
    pr_we   = cmd_i.alloc_wr | cmd_i.enq_wr;
    pr_re   = cmd_i.dq_take;
    pk_slot = cmd_i.alloc_wr ? new_slot : idx_q;
    if (cmd_i.alloc_wr) begin
      pk_pos = '0;
    end else if (cmd_i.dq_take) begin
      pk_pos = fr_rd_ent.head;
    end else begin
      pk_pos = fr_rd_ent.tail;
    end
    pk_addr = PADDR_W'(pk_slot) * PADDR_W'(QUEUE_DEPTH) + PADDR_W'(pk_pos);
  end

  rrfqs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_FLOWS)
  ) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wr_ent),
    .re_i    (fr_re),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  rrfqs_ram #(
    .WIDTH (16),
    .DEPTH (PKT_DEPTH)
  ) u_pkt_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (pk_addr),
    .wdata_i (req_q.packet_id),
    .re_i    (pr_re),
    .raddr_i (pk_addr),
    .rdata_o (pr_rdata)
  );

  // Control registers: flow count, service pointer, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nflows_q    <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.alloc_wr) begin
        nflows_q <= nflows_q + NUM_W'(1);
      end
      if (cmd_i.dq_take) begin
        ptr_q <= idx_wrap;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_word_i;
    end
    if (cmd_i.lk_start) begin
      idx_q <= '0;
    end else if (cmd_i.lk_next) begin
      idx_q <= idx_inc;
    end else if (cmd_i.dq_start) begin
      idx_q   <= ptr_q;
      steps_q <= '0;
    end else if (cmd_i.dq_next) begin
      idx_q   <= idx_wrap;
      steps_q <= steps_q + SLOT_W'(1);
    end
    if (cmd_i.dq_take) begin
      key_q <= fr_rd_ent.key;
    end
    if (cmd_i.res_set) begin
      res_q.status        <= cmd_i.res_status;
      res_q.out_packet_id <= cmd_i.res_pkt ? pr_rdata : '0;
      res_q.out_flow_id   <= cmd_i.res_pkt ? key_q : '0;
    end
    if (cmd_i.out_load) begin
      out_word_q <= res_q;
    end
  end

  // Status back to the controller
  assign sts_o.req_deq        = (req_q.req_type == rrfqs_pkg::REQ_DEQ);
  assign sts_o.no_flows       = (nflows_q == '0);
  assign sts_o.table_full     = (nflows_q == NUM_W'(MAX_FLOWS));
  assign sts_o.key_match      = (fr_rd_ent.key == req_q.flow_id);
  assign sts_o.idx_last       = idx_last;
  assign sts_o.queue_full     = (fr_rd_ent.count == CNT_W'(QUEUE_DEPTH));
  assign sts_o.queue_nonempty = (fr_rd_ent.count != '0);
  assign sts_o.steps_last     = steps_last;
  assign sts_o.out_free       = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Flow count stays within the table
  `RRFQS_ASSERT(a_nflows_range, nflows_q <= NUM_W'(MAX_FLOWS))
  // Service pointer points at an allocated slot
  `RRFQS_IMPLIES(a_ptr_in_use, nflows_q != '0, NUM_W'(ptr_q) < nflows_q)
  // Allocation grows the table by exactly one
  `RRFQS_NEXT(a_alloc_grows, cmd_i.alloc_wr, nflows_q == NUM_W'($past(nflows_q) + 1))
  // A new result never overwrites one still waiting
  `RRFQS_IMPLIES(a_out_no_overwrite, cmd_i.out_load, !out_valid_q || !out_stall_i)

endmodule

// File: hw/rtl/round_robin_flow_queue_scheduler_top.sv
// ----------------------------------------------------------------------------
// Round-robin flow queue scheduler
// Per-flow packet FIFOs with first-arrival slot allocation and round-robin
// service across flows.
// ----------------------------------------------------------------------------
// Each input word is an enqueue (flow id, packet id) or a dequeue, and gives
// exactly one output word. Words are handled one at a time. An enqueue
// compares flow slots in order up to a match or, for a new flow or a full
// table, through all the flows in use. A dequeue examines slots from the
// service pointer up to the first one with a packet queued, or through all
// the flows in use when nothing is queued. The scan of the flow-state memory
// covers one slot per cycle. A stalled output delays the return to idle
// until the output register is free. The output register lets a new word be
// accepted while the last result is still stalled. Memories need no clearing
// after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_flow_queue_scheduler_top #(
  parameter int MAX_FLOWS   = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rrfqs_pkg::req_t   in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rrfqs_pkg::rsp_t   out_word_o
);

  rrfqs_pkg::cmd_t cmd;
  rrfqs_pkg::sts_t sts;

  // Sequencer
  rrfqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic
  rrfqs_dp #(
    .MAX_FLOWS   (MAX_FLOWS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

// File: tb/sv/round_robin_flow_queue_scheduler_top_test.sv
// ----------------------------------------------------------------------------
// Round-robin flow queue scheduler: self-checking testbench
// Drives enqueue and dequeue words with random gaps and output stalls. A
// per-flow FIFO model in the bench predicts each result word, and every
// result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_flow_queue_scheduler_top_test;

  localparam int MAX_FLOWS      = 16;
  localparam int QUEUE_DEPTH    = 16;
  localparam int RANDOM_WORDS   = 2000;
  localparam int FLOW_POOL      = 20;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int SIDE_TX        = 0;
  localparam int SIDE_RX        = 1;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  rrfqs_pkg::req_t in_word_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  rrfqs_pkg::rsp_t out_word_o;

  // Scheduler state mirrored by the bench
  logic [15:0] flow_key  [MAX_FLOWS];
  logic [15:0] pkt_store [MAX_FLOWS][QUEUE_DEPTH];
  int          q_head    [MAX_FLOWS] = '{default: 0};
  int          q_tail    [MAX_FLOWS] = '{default: 0};
  int          q_count   [MAX_FLOWS] = '{default: 0};
  int          flows_used = 0;
  int          svc_ptr    = 0;

  rrfqs_pkg::rsp_t due_words[$];
  logic [15:0]     flow_pool [FLOW_POOL];
  int              mismatch_count = 0;
  int              rx_hold_cycles = 0;
  int              calm_left [2]  = '{default: 0};
  bit              idle_free [2];

  always #5 clk_i = ~clk_i;

  round_robin_flow_queue_scheduler_top #(
    .MAX_FLOWS  (MAX_FLOWS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Apply one request to the mirrored state and return the result word
  function automatic rrfqs_pkg::rsp_t predict_service(rrfqs_pkg::req_t w);
    rrfqs_pkg::rsp_t r;
    int   slot;
    int   base;
    int   s;
    int   i;
    r.status        = rrfqs_pkg::STATUS_OK;
    r.out_packet_id = '0;
    r.out_flow_id   = '0;
    if (w.req_type == rrfqs_pkg::REQ_ENQ) begin
      slot = -1;
      for (i = 0; i < flows_used; i++) begin
        if (slot < 0 && flow_key[i] == w.flow_id) slot = i;
      end
      // allocate the next slot for an unseen flow
      if (slot < 0) begin
        if (flows_used >= MAX_FLOWS) begin
          r.status = rrfqs_pkg::STATUS_TABLE_FULL;
          return r;
        end
        slot           = flows_used;
        flow_key[slot] = w.flow_id;
        q_head[slot]   = 0;
        q_tail[slot]   = 0;
        q_count[slot]  = 0;
        flows_used++;
      end
      if (q_count[slot] >= QUEUE_DEPTH) begin
        r.status = rrfqs_pkg::STATUS_QUEUE_FULL;
      end else begin
        pkt_store[slot][q_tail[slot]] = w.packet_id;
        q_tail[slot] = (q_tail[slot] + 1) % QUEUE_DEPTH;
        q_count[slot]++;
      end
    end else begin
      // search from the service pointer for the first non-empty flow
      r.status = rrfqs_pkg::STATUS_EMPTY;
      if (flows_used != 0) begin
        base = svc_ptr % flows_used;
        for (i = 0; i < flows_used; i++) begin
          s = (base + i) % flows_used;
          if (r.status == rrfqs_pkg::STATUS_EMPTY && q_count[s] != 0) begin
            r.status        = rrfqs_pkg::STATUS_OK;
            r.out_packet_id = pkt_store[s][q_head[s]];
            r.out_flow_id   = flow_key[s];
            q_head[s]       = (q_head[s] + 1) % QUEUE_DEPTH;
            q_count[s]--;
            svc_ptr         = (s + 1) % flows_used;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Draw a wait per word; alternate stretches of random gaps and no gaps
  function automatic int draw_idle(int side);
    if (calm_left[side] == 0) begin
      calm_left[side] = $urandom_range(10, 60);
      idle_free[side] = ($urandom_range(0, 2) == 0);
    end
    calm_left[side]--;
    return idle_free[side] ? 0 : $urandom_range(0, 18);
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(rrfqs_pkg::req_t w);
    int gap;
    gap = draw_idle(SIDE_TX);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Predict on input acceptance, compare on output acceptance
  always @(posedge clk_i) begin : scoreboard
    rrfqs_pkg::rsp_t want;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        if (due_words.size() == 0) begin
          report_mismatch("result word with nothing pending", out_word_o.out_packet_id, '0);
        end else begin
          want = due_words.pop_front();
          if (out_word_o.status !== want.status)
            report_mismatch("status", 16'(out_word_o.status), 16'(want.status));
          if (out_word_o.out_packet_id !== want.out_packet_id)
            report_mismatch("packet id", out_word_o.out_packet_id, want.out_packet_id);
          if (out_word_o.out_flow_id !== want.out_flow_id)
            report_mismatch("flow id", out_word_o.out_flow_id, want.out_flow_id);
        end
      end
      if (in_valid_i == 1'b1 && in_stall_o === 1'b0)
        due_words.insert(due_words.size(), predict_service(in_word_i));
    end
  end

  // Stall the output side per word, with an optional long hold-off
  initial begin : result_sink
    int gap;
    forever begin
      if (rx_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      gap = draw_idle(SIDE_RX);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // End the run when no word moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("round_robin_flow_queue_scheduler_top_test: done, errors");
    $finish;
  end

  function automatic rrfqs_pkg::req_t make_word(rrfqs_pkg::req_e kind, logic [15:0] flow,
                                                logic [15:0] pkt);
    rrfqs_pkg::req_t w;
    w.req_type  = kind;
    w.flow_id   = flow;
    w.packet_id = pkt;
    return w;
  endfunction

  // Field extremes, round-robin order, empty dequeues and a full flow queue
  task automatic test_directed_cases();
    int k;
    send_word(make_word(rrfqs_pkg::REQ_DEQ, 16'hFFFF, 16'hFFFF));
    send_word(make_word(rrfqs_pkg::REQ_ENQ, 16'h0000, 16'h0000));
    send_word(make_word(rrfqs_pkg::REQ_ENQ, 16'hFFFF, 16'hFFFF));
    send_word(make_word(rrfqs_pkg::REQ_ENQ, 16'h0000, 16'hFFFF));
    send_word(make_word(rrfqs_pkg::REQ_ENQ, 16'hFFFF, 16'h0000));
    for (k = 0; k < 4; k++) send_word(make_word(rrfqs_pkg::REQ_DEQ, 16'h0000, 16'h0000));
    // every queue empty while flows exist
    send_word(make_word(rrfqs_pkg::REQ_DEQ, 16'h5A5A, 16'hA5A5));
    // fill one flow, then overflow it
    for (k = 0; k <= QUEUE_DEPTH; k++)
      send_word(make_word(rrfqs_pkg::REQ_ENQ, 16'h8000, 16'(k * 16'h1111)));
  endtask

  // Hold the output off while the sender keeps offering words
  task automatic test_output_backpressure();
    int              k;
    rrfqs_pkg::req_e kind;
    rx_hold_cycles = LONG_HOLD;
    for (k = 0; k < 24; k++) begin
      kind = (k % 3 == 2) ? rrfqs_pkg::REQ_DEQ : rrfqs_pkg::REQ_ENQ;
      send_word(make_word(kind, flow_pool[k % 4], 16'($urandom)));
    end
  endtask

  // Phases of varied enqueue share over a varied set of flows
  task automatic test_random_traffic(int n_words);
    int              sent;
    int              phase_len;
    int              enq_pct;
    int              focus;
    int              base;
    int              k;
    rrfqs_pkg::req_t w;
    sent = 0;
    while (sent < n_words) begin
      phase_len = $urandom_range(40, 150);
      case ($urandom_range(0, 2))
        0: enq_pct = 30;
        1: enq_pct = 55;
        default: enq_pct = 80;
      endcase
      focus = $urandom_range(1, FLOW_POOL);
      base  = $urandom_range(0, FLOW_POOL - 1);
      for (k = 0; k < phase_len && sent < n_words; k++) begin
        w.flow_id   = 16'($urandom);
        w.packet_id = 16'($urandom);
        if ($urandom_range(0, 99) < enq_pct) begin
          w.req_type = rrfqs_pkg::REQ_ENQ;
          // mostly known flows; now and then a fresh id
          if ($urandom_range(0, 49) != 0)
            w.flow_id = flow_pool[(base + $urandom_range(0, focus - 1)) % FLOW_POOL];
        end else begin
          w.req_type = rrfqs_pkg::REQ_DEQ;
        end
        send_word(w);
        sent++;
      end
    end
  endtask

  initial begin : test_sequence
    int k;
    flow_pool[0] = 16'h0000;
    flow_pool[1] = 16'hFFFF;
    flow_pool[2] = 16'h8000;
    for (k = 3; k < FLOW_POOL; k++) flow_pool[k] = 16'($urandom);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_output_backpressure();
    test_random_traffic(RANDOM_WORDS);
    in_valid_i <= 1'b0;

    // drain outstanding results; the watchdog bounds this wait
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("round_robin_flow_queue_scheduler_top_test: done, clean");
    end else begin
      $display("round_robin_flow_queue_scheduler_top_test: done, errors");
    end
    $finish;
  end

endmodule
